// ===== hw/rtl/wmh_pkg.sv =====
`default_nettype none

package wmh_pkg;

	localparam logic [63:0] WMH_GOLDEN_SEED = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] WMH_WORD_MUL    = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] WMH_HASH_MUL    = 64'h94D049BB133111EB;
	localparam logic [63:0] WMH_FINAL_MUL   = 64'hFF51AFD7ED558CCD;
	localparam int unsigned WMH_WORD_SHIFT  = 31;
	localparam int unsigned WMH_FINAL_SHIFT = 33;

	localparam int unsigned WMH_QUEUE_DEPTH = 2;

	// one classified word waiting for the back end
	typedef struct packed {
		logic [63:0] word;
		logic        has_data;
		logic        first;
		logic        last;
		logic [31:0] total;
	} wmh_item_t;

	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} wmh_mul_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] p;
	} wmh_mul_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/word_mix_hash_64to32_core.sv =====
// channel  | handshake          | fields
// ---------+--------------------+----------------------------------------------------
// input    | push / full        | data_word, valid_bytes, first_word, last_word,
//          |                    | total_length
// result   | pop / empty        | hash_value
//
// one shared 32x32 multiplier forms each 64-bit product in three passes
// a word takes a word and a hash multiply; first adds a seed multiply, last a final multiply
// a 2-word queue parts the input side from the hash engine
// a waiting result holds the engine at its next finalization; input stalls once the queue fills
// reset clears the running hash to zero
`default_nettype none

module word_mix_hash_64to32_core import wmh_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = WMH_QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [63:0] data_word,
	input  wire logic [3:0]  valid_bytes,
	input  wire logic        first_word,
	input  wire logic        last_word,
	input  wire logic [31:0] total_length,
	output logic             empty,
	input  wire logic        pop,
	output logic [31:0]      hash_value
);

	logic         q_empty;
	logic         q_pop;
	wmh_item_t    q_head;
	wmh_mul_req_t mul_req;
	wmh_mul_rsp_t mul_rsp;

	wmh_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.data_word   (data_word),
		.valid_bytes (valid_bytes),
		.first_word  (first_word),
		.last_word   (last_word),
		.total_length(total_length),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.q_head      (q_head)
	);

	wmh_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mul_req),
		.rsp   (mul_rsp)
	);

	wmh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.q_head    (q_head),
		.mul_req   (mul_req),
		.mul_rsp   (mul_rsp),
		.empty     (empty),
		.pop       (pop),
		.hash_value(hash_value)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/wmh_front.sv =====
`default_nettype none

module wmh_front import wmh_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = WMH_QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [63:0] data_word,
	input  wire logic [3:0]  valid_bytes,
	input  wire logic        first_word,
	input  wire logic        last_word,
	input  wire logic [31:0] total_length,
	output logic             q_empty,
	input  wire logic        q_pop,
	output wmh_item_t        q_head
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	wmh_item_t        slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [63:0]      masked_word;
	wmh_item_t        in_item;
	logic             do_push;
	logic             do_pop;

	// clear the unused upper bytes of the word
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			masked_word[i*8 +: 8] = (valid_bytes > 4'(i)) ? data_word[i*8 +: 8] : 8'h00;
		end
	end

	always_comb begin
		in_item.word     = masked_word;
		in_item.has_data = (valid_bytes != 4'd0);
		in_item.first    = first_word;
		in_item.last     = last_word;
		in_item.total    = total_length;
	end

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign q_empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = q_pop && !q_empty;
	assign q_head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> count_q != '0)
		else $error("back end pops an empty queue");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/wmh_mul.sv =====
`default_nettype none

module wmh_mul import wmh_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire wmh_mul_req_t req,
	output wmh_mul_rsp_t      rsp
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LL,
		PH_LH,
		PH_HL,
		PH_LAST
	} phase_t;

	phase_t      phase_q;
	logic [63:0] prod_q;
	logic [63:0] acc_q;
	logic        done_q;
	logic [31:0] op_x;
	logic [31:0] op_y;

	// low 64 bits of a*b from three 32x32 partial products
	always_comb begin
		unique case (phase_q)
			PH_LH: begin
				op_x = req.a[31:0];
				op_y = req.b[63:32];
			end
			PH_HL: begin
				op_x = req.a[63:32];
				op_y = req.b[31:0];
			end
			default: begin
				op_x = req.a[31:0];
				op_y = req.b[31:0];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= {32'd0, op_x} * {32'd0, op_y};
		unique case (phase_q)
			PH_LH: acc_q <= prod_q;
			PH_HL, PH_LAST: acc_q <= acc_q + {prod_q[31:0], 32'd0};
			default: acc_q <= acc_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				PH_IDLE: if (req.start) phase_q <= PH_LL;
				PH_LL: phase_q <= PH_LH;
				PH_LH: phase_q <= PH_HL;
				PH_HL: phase_q <= PH_LAST;
				PH_LAST: begin
					phase_q <= PH_IDLE;
					done_q  <= 1'b1;
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.p    = acc_q;

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> phase_q == PH_IDLE)
		else $error("multiplier started while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !rsp.done)
		else $error("multiplier done held longer than one cycle");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/wmh_back.sv =====
`default_nettype none

module wmh_back import wmh_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         q_empty,
	output logic              q_pop,
	input  wire wmh_item_t    q_head,
	output wmh_mul_req_t      mul_req,
	input  wire wmh_mul_rsp_t mul_rsp,
	output logic              empty,
	input  wire logic         pop,
	output logic [31:0]       hash_value
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEED,
		S_WORD,
		S_HASH,
		S_FINAL,
		S_OUT
	} state_t;

	state_t      state_q;
	logic [63:0] word_q;
	logic        has_q;
	logic        last_q;
	logic [63:0] hash_q;
	logic        start_q;
	logic [63:0] a_q;
	logic [63:0] b_q;
	logic        out_valid_q;
	logic [31:0] hash_value_q;
	logic [63:0] seed_fold;
	logic [63:0] hash_fold;
	logic [63:0] prod_fold;
	logic [63:0] word_mix;
	logic [31:0] final_low;

	assign seed_fold = hash_q ^ (hash_q >> WMH_FINAL_SHIFT);
	assign hash_fold = mul_rsp.p ^ (mul_rsp.p >> WMH_FINAL_SHIFT);
	assign prod_fold = hash_fold;
	assign word_mix  = mul_rsp.p ^ (mul_rsp.p >> WMH_WORD_SHIFT);
	assign final_low = prod_fold[31:0];

	assign q_pop      = (state_q == S_IDLE) && !q_empty;
	assign mul_req    = '{start: start_q, a: a_q, b: b_q};
	assign empty      = !out_valid_q;
	assign hash_value = hash_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			hash_q      <= '0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						word_q <= q_head.word;
						has_q  <= q_head.has_data;
						last_q <= q_head.last;
						if (q_head.first) begin
							a_q     <= {32'd0, q_head.total};
							b_q     <= WMH_GOLDEN_SEED;
							start_q <= 1'b1;
							state_q <= S_SEED;
						end else if (q_head.has_data) begin
							a_q     <= q_head.word;
							b_q     <= WMH_WORD_MUL;
							start_q <= 1'b1;
							state_q <= S_WORD;
						end else if (q_head.last) begin
							a_q     <= seed_fold;
							b_q     <= WMH_FINAL_MUL;
							start_q <= 1'b1;
							state_q <= S_FINAL;
						end
					end
				end
				S_SEED: begin
					if (mul_rsp.done) begin
						hash_q <= mul_rsp.p;
						if (has_q) begin
							a_q     <= word_q;
							b_q     <= WMH_WORD_MUL;
							start_q <= 1'b1;
							state_q <= S_WORD;
						end else if (last_q) begin
							a_q     <= hash_fold;
							b_q     <= WMH_FINAL_MUL;
							start_q <= 1'b1;
							state_q <= S_FINAL;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_WORD: begin
					if (mul_rsp.done) begin
						a_q     <= hash_q ^ word_mix;
						b_q     <= WMH_HASH_MUL;
						start_q <= 1'b1;
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (mul_rsp.done) begin
						hash_q <= mul_rsp.p;
						if (last_q) begin
							a_q     <= hash_fold;
							b_q     <= WMH_FINAL_MUL;
							start_q <= 1'b1;
							state_q <= S_FINAL;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_FINAL: begin
					if (mul_rsp.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// product stays on the multiplier output until the next start
					if (!out_valid_q) begin
						out_valid_q  <= 1'b1;
						hash_value_q <= final_low;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> (state_q == S_SEED || state_q == S_WORD ||
			state_q == S_HASH || state_q == S_FINAL))
		else $error("product arrived while nothing waits for it");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && !out_valid_q) |=> out_valid_q && state_q == S_IDLE)
		else $error("result not loaded into free output register");
`endif

endmodule

`default_nettype wire
